// ----- rtl/core/slph_pkg.sv -----
package slph_pkg;

    localparam int SHARD_BITS_DEF  = 4;
    localparam int BUCKET_BITS_DEF = 8;

    // Fibonacci hash multiplier, split into 32-bit halves.
    localparam logic [31:0] FIB_LO = 32'h7F4A_7C15;
    localparam logic [31:0] FIB_HI = 32'h9E37_79B9;

    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd4;

    localparam logic [7:0] LOAD_LIMIT_RST = 8'd192;
    localparam int         PADDR_W        = 3;
    localparam logic       REG_LOAD_LIMIT = 1'b0;

    typedef struct packed {
        logic rd;
        logic wr_key;
        logic wr_data;
    } mem_cmd_t;

endpackage

// ----- rtl/core/slph_if.sv -----
interface slph_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] new_key;
    logic [63:0] data_in;

    modport source (output valid, cmd, key, new_key, data_in, input ready);
    modport sink (input valid, cmd, key, new_key, data_in, output ready);
endinterface

interface slph_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] data_out;

    modport source (output valid, status, data_out, input ready);
    modport sink (input valid, status, data_out, output ready);
endinterface

// ----- rtl/core/slph_hash.sv -----
module slph_hash
    import slph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [31:0] hash_hi
);

    logic [1:0]  step_reg;
    logic [63:0] key_reg;
    logic [31:0] acc_reg;
    logic        done_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;

    always_comb
    begin
        op_a = key_reg[31:0];
        op_b = FIB_LO;
        case (step_reg)
            2'd2:
            begin
                op_b = FIB_HI;
            end
            2'd3:
            begin
                op_a = key_reg[63:32];
            end
            default:
            begin
                op_b = FIB_LO;
            end
        endcase
        prod = op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 2'd3);
            case (step_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        key_reg  <= key;
                        step_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    acc_reg  <= prod[63:32];
                    step_reg <= 2'd2;
                end
                2'd2:
                begin
                    acc_reg  <= acc_reg + prod[31:0];
                    step_reg <= 2'd3;
                end
                default:
                begin
                    acc_reg  <= acc_reg + prod[31:0];
                    step_reg <= 2'd0;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign hash_hi = acc_reg;

endmodule

// ----- rtl/core/slph_store.sv -----
module slph_store
    import slph_pkg::*;
#(
    parameter int AW = SHARD_BITS_DEF + BUCKET_BITS_DEF
)
(
    input  logic          clk,
    input  mem_cmd_t      cmd,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_key,
    input  logic [63:0]   wr_data,
    output logic [63:0]   rd_key,
    output logic [63:0]   rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [63:0] key_mem [DEPTH];
    logic [63:0] data_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (cmd.wr_data)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_data <= data_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/slph_ctrl.sv -----
module slph_ctrl
    import slph_pkg::*;
#(
    parameter int SHARD_BITS  = SHARD_BITS_DEF,
    parameter int BUCKET_BITS = BUCKET_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        load_limit,
    slph_in_if.sink                           in_ch,
    slph_out_if.source                        out_ch,
    output logic                              hash_start,
    output logic [63:0]                       hash_key,
    input  logic                              hash_done,
    input  logic [31:0]                       hash_hi,
    output mem_cmd_t                          mem_cmd,
    output logic [SHARD_BITS+BUCKET_BITS-1:0] mem_rd_addr,
    output logic [SHARD_BITS+BUCKET_BITS-1:0] mem_wr_addr,
    output logic [63:0]                       mem_wr_key,
    output logic [63:0]                       mem_wr_data,
    input  logic [63:0]                       mem_rd_key,
    input  logic [63:0]                       mem_rd_data
);

    localparam int AW  = SHARD_BITS + BUCKET_BITS;
    localparam int BB  = BUCKET_BITS;
    localparam int SHW = (SHARD_BITS > 0) ? SHARD_BITS : 1;
    localparam int NS  = 1 << SHARD_BITS;
    localparam int FW  = BUCKET_BITS + 1;
    localparam int CW  = (FW > 8) ? FW : 8;
    localparam logic [FW-1:0] NB_M1 = FW'((1 << BUCKET_BITS) - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_LRD   = 4'd4;
    localparam logic [3:0] S_LCMP  = 4'd5;
    localparam logic [3:0] S_PLACE = 4'd6;
    localparam logic [3:0] S_UPW   = 4'd7;
    localparam logic [3:0] S_RMV0  = 4'd8;
    localparam logic [3:0] S_BRD   = 4'd9;
    localparam logic [3:0] S_BCHK  = 4'd10;
    localparam logic [3:0] S_BHASH = 4'd11;
    localparam logic [3:0] S_BMV1  = 4'd12;
    localparam logic [3:0] S_BMV2  = 4'd13;
    localparam logic [3:0] S_RDONE = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]     state_reg;
    logic [AW-1:0]  clr_reg;
    logic [1:0]     cmd_reg;
    logic [63:0]    key_reg;
    logic [63:0]    nkey_reg;
    logic [63:0]    data_reg;
    logic [SHW-1:0] shard_reg;
    logic [BB-1:0]  idx_reg;
    logic [BB-1:0]  curr_reg;
    logic [BB-1:0]  next_reg;
    logic [FW-1:0]  n_reg;
    logic           upd2_reg;
    logic           nocheck_reg;
    logic [63:0]    mv_key_reg;
    logic [63:0]    mv_data_reg;
    logic [2:0]     status_reg;
    logic [63:0]    dout_reg;
    logic           hstart_reg;
    logic           hstart_next;
    logic [63:0]    hkey_reg;
    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic [63:0]    out_data_reg;
    logic [FW-1:0]  fill_reg [NS];

    logic [SHW-1:0] h_shard;
    logic [BB-1:0]  h_home;
    logic [BB-1:0]  dnext;
    logic [BB-1:0]  dcurr;
    logic [FW-1:0]  fill_cur;
    logic           is_full;
    logic           out_free;

    assign h_shard  = (SHARD_BITS > 0) ? hash_hi[31 -: SHW] : '0;
    assign h_home   = hash_hi[BB-1:0];
    assign dnext    = next_reg - h_home;
    assign dcurr    = curr_reg - h_home;
    assign fill_cur = fill_reg[shard_reg];
    assign is_full  = (CW'(fill_cur) >= CW'(load_limit)) || (fill_cur >= NB_M1);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign hstart_next = (state_reg == S_IDLE && in_ch.valid && in_ch.key != '0
                          && !(in_ch.cmd == CMD_UPDATE && in_ch.new_key == '0))
                      || (state_reg == S_BCHK && mem_rd_key != '0)
                      || (state_reg == S_RDONE && cmd_reg == CMD_UPDATE);

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.data_out = out_data_reg;
    assign hash_start      = hstart_reg;
    assign hash_key        = hkey_reg;

    always_comb
    begin
        mem_cmd     = '0;
        mem_rd_addr = AW'({shard_reg, idx_reg});
        mem_wr_addr = AW'({shard_reg, idx_reg});
        mem_wr_key  = '0;
        mem_wr_data = data_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.wr_key = 1'b1;
                mem_wr_addr    = clr_reg;
            end
            S_LRD:
            begin
                mem_cmd.rd = 1'b1;
            end
            S_BRD:
            begin
                mem_cmd.rd  = 1'b1;
                mem_rd_addr = AW'({shard_reg, next_reg});
            end
            S_RMV0:
            begin
                mem_cmd.wr_key = 1'b1;
            end
            S_BMV1:
            begin
                mem_cmd.wr_key  = 1'b1;
                mem_cmd.wr_data = 1'b1;
                mem_wr_addr     = AW'({shard_reg, curr_reg});
                mem_wr_key      = mv_key_reg;
                mem_wr_data     = mv_data_reg;
            end
            S_BMV2:
            begin
                mem_cmd.wr_key = 1'b1;
                mem_wr_addr    = AW'({shard_reg, next_reg});
            end
            S_UPW:
            begin
                mem_cmd.wr_data = 1'b1;
            end
            S_PLACE:
            begin
                mem_cmd.wr_key  = 1'b1;
                mem_cmd.wr_data = 1'b1;
                mem_wr_key      = key_reg;
            end
            default:
            begin
                mem_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hstart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            hstart_reg <= hstart_next;
            if (out_valid_reg && out_ch.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        cmd_reg     <= in_ch.cmd;
                        key_reg     <= in_ch.key;
                        nkey_reg    <= in_ch.new_key;
                        data_reg    <= in_ch.data_in;
                        upd2_reg    <= 1'b0;
                        nocheck_reg <= 1'b0;
                        dout_reg    <= '0;
                        if (in_ch.key == '0 || (in_ch.cmd == CMD_UPDATE && in_ch.new_key == '0))
                        begin
                            status_reg <= ST_ZERO_KEY;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            hkey_reg   <= in_ch.key;
                            state_reg  <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        shard_reg <= h_shard;
                        idx_reg   <= h_home;
                        n_reg     <= '0;
                        if (upd2_reg && h_shard == shard_reg)
                        begin
                            nocheck_reg <= 1'b1;
                            state_reg   <= S_LRD;
                        end
                        else if (cmd_reg == CMD_INSERT)
                        begin
                            state_reg <= S_CHK;
                        end
                        else
                        begin
                            state_reg <= S_LRD;
                        end
                    end
                end
                S_CHK:
                begin
                    if (is_full)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_LRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LCMP;
                end
                S_LCMP:
                begin
                    if (mem_rd_key != '0 && !nocheck_reg && mem_rd_key == key_reg)
                    begin
                        case (cmd_reg)
                            CMD_FIND:
                            begin
                                dout_reg   <= mem_rd_data;
                                status_reg <= ST_OK;
                                state_reg  <= S_FIN;
                            end
                            CMD_INSERT:
                            begin
                                status_reg <= ST_EXISTS;
                                state_reg  <= S_FIN;
                            end
                            CMD_DELETE:
                            begin
                                dout_reg   <= mem_rd_data;
                                status_reg <= ST_OK;
                                state_reg  <= S_RMV0;
                            end
                            default:
                            begin
                                status_reg <= ST_OK;
                                state_reg  <= (key_reg == nkey_reg) ? S_UPW : S_RMV0;
                            end
                        endcase
                    end
                    else if (mem_rd_key == '0 || n_reg == NB_M1)
                    begin
                        if (cmd_reg == CMD_INSERT)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= (mem_rd_key == '0) ? S_PLACE : S_FIN;
                        end
                        else
                        begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= S_FIN;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_LRD;
                    end
                end
                S_PLACE:
                begin
                    fill_reg[shard_reg] <= fill_cur + 1'b1;
                    state_reg           <= S_FIN;
                end
                S_UPW:
                begin
                    state_reg <= S_FIN;
                end
                S_RMV0:
                begin
                    if (fill_cur != '0)
                    begin
                        fill_reg[shard_reg] <= fill_cur - 1'b1;
                    end
                    curr_reg  <= idx_reg;
                    next_reg  <= idx_reg + 1'b1;
                    n_reg     <= '0;
                    state_reg <= S_BRD;
                end
                S_BRD:
                begin
                    state_reg <= S_BCHK;
                end
                S_BCHK:
                begin
                    if (mem_rd_key == '0)
                    begin
                        state_reg <= S_RDONE;
                    end
                    else
                    begin
                        mv_key_reg  <= mem_rd_key;
                        mv_data_reg <= mem_rd_data;
                        hkey_reg    <= mem_rd_key;
                        state_reg   <= S_BHASH;
                    end
                end
                S_BHASH:
                begin
                    if (hash_done)
                    begin
                        if (dcurr < dnext)
                        begin
                            state_reg <= S_BMV1;
                        end
                        else
                        begin
                            next_reg  <= next_reg + 1'b1;
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= (n_reg == NB_M1) ? S_RDONE : S_BRD;
                        end
                    end
                end
                S_BMV1:
                begin
                    state_reg <= S_BMV2;
                end
                S_BMV2:
                begin
                    curr_reg  <= next_reg;
                    next_reg  <= next_reg + 1'b1;
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= (n_reg == NB_M1) ? S_RDONE : S_BRD;
                end
                S_RDONE:
                begin
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        cmd_reg    <= CMD_INSERT;
                        key_reg    <= nkey_reg;
                        upd2_reg   <= 1'b1;
                        hkey_reg   <= nkey_reg;
                        state_reg  <= S_HASH;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_data_reg   <= (status_reg == ST_OK) ? dout_reg : 64'd0;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/sharded_linear_probe_hash_map.sv -----
// Key/data map for nonzero 64-bit keys, split into shards of linearly probed
// buckets held in one key memory and one data memory. After reset the block
// clears the key memory, one bucket a cycle, all 2^(SHARD_BITS+BUCKET_BITS)
// buckets (4096 by default), and takes no word meanwhile; load_limit may be
// written at any time. One word is worked on at a time: hashing forms its
// partial products in turn on a shared 32-bit multiplier, a probe reads then
// compares, and each bucket that delete or a rekeying update walks past costs
// a further hash of its key plus a move and a clear write when it moves. A
// find that hits at its home bucket passes S_HASH, S_LRD and S_LCMP to S_FIN;
// a new word is taken while the previous result waits at the output register.
module sharded_linear_probe_hash_map
    import slph_pkg::*;
#(
    parameter int SHARD_BITS  = SHARD_BITS_DEF,
    parameter int BUCKET_BITS = BUCKET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    slph_in_if.sink            in_ch,
    slph_out_if.source         out_ch
);

    localparam int AW = SHARD_BITS + BUCKET_BITS;

    logic [7:0]    load_limit_reg;
    logic          hash_start;
    logic [63:0]   hash_key;
    logic          hash_done;
    logic [31:0]   hash_hi;
    mem_cmd_t      mem_cmd;
    logic [AW-1:0] mem_rd_addr;
    logic [AW-1:0] mem_wr_addr;
    logic [63:0]   mem_wr_key;
    logic [63:0]   mem_wr_data;
    logic [63:0]   mem_rd_key;
    logic [63:0]   mem_rd_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOAD_LIMIT) ? {24'd0, load_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= LOAD_LIMIT_RST;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_LOAD_LIMIT)
        begin
            load_limit_reg <= pwdata[7:0];
        end
    end

    slph_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .hash_hi (hash_hi)
    );

    slph_store #(
        .AW (AW)
    ) u_store (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_key  (mem_wr_key),
        .wr_data (mem_wr_data),
        .rd_key  (mem_rd_key),
        .rd_data (mem_rd_data)
    );

    slph_ctrl #(
        .SHARD_BITS  (SHARD_BITS),
        .BUCKET_BITS (BUCKET_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_limit  (load_limit_reg),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .hash_start  (hash_start),
        .hash_key    (hash_key),
        .hash_done   (hash_done),
        .hash_hi     (hash_hi),
        .mem_cmd     (mem_cmd),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_key  (mem_wr_key),
        .mem_wr_data (mem_wr_data),
        .mem_rd_key  (mem_rd_key),
        .mem_rd_data (mem_rd_data)
    );

endmodule

// ----- rtl/core/slph_checker.sv -----
module slph_checker
    import slph_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [63:0] out_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_OK || out_status == ST_NOT_FOUND ||
                       out_status == ST_EXISTS || out_status == ST_FULL ||
                       out_status == ST_ZERO_KEY))
        else $error("result word carries an unknown status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ST_OK) |-> (out_data == 64'd0))
        else $error("failed operation returned nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_data)))
        else $error("stalled result word changed");

endmodule

bind sharded_linear_probe_hash_map slph_checker u_slph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_data   (out_ch.data_out)
);

// ----- bench/slph_map_checker.sv -----
`timescale 1ns / 100ps

module slph_map_checker
    import slph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    slph_in_if          in_ch,
    slph_out_if         out_ch,
    output int          errors,
    output int          pending,
    output int          words_done
);

    localparam int NB = 1 << BUCKET_BITS_DEF;
    localparam int NS = 1 << SHARD_BITS_DEF;
    localparam logic [63:0] FIB_MUL = {FIB_HI, FIB_LO};

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data;
    } map_reply_t;

    logic [63:0] key_mem  [NS*NB];
    logic [63:0] data_mem [NS*NB];
    int          shard_fill [NS];
    logic [7:0]  load_limit;
    map_reply_t  replies_due [$];

    function automatic logic [63:0] fib_hash(logic [63:0] k);
        return k * FIB_MUL;
    endfunction

    function automatic int shard_sel(logic [63:0] k);
        logic [63:0] h;
        h = fib_hash(k);
        return int'(h[63 -: SHARD_BITS_DEF]);
    endfunction

    function automatic int home_bucket(logic [63:0] k);
        logic [63:0] h;
        h = fib_hash(k);
        return int'(h[32 +: BUCKET_BITS_DEF]);
    endfunction

    function automatic int bucket_at(int s, int b);
        return s * NB + (b % NB);
    endfunction

    function automatic bit find_bucket(int s, logic [63:0] k, output int pos);
        int idx;
        idx = home_bucket(k);
        pos = 0;
        for (int n = 0; n < NB; n++)
        begin
            if (key_mem[bucket_at(s, idx)] == 64'd0)
                return 1'b0;
            if (key_mem[bucket_at(s, idx)] == k)
            begin
                pos = idx;
                return 1'b1;
            end
            idx = (idx + 1) % NB;
        end
        return 1'b0;
    endfunction

    function automatic void shift_back_from(int s, int idx);
        int cur;
        int nxt;
        int ideal;
        int dn;
        int dc;
        logic [63:0] k;
        key_mem[bucket_at(s, idx)] = 64'd0;
        data_mem[bucket_at(s, idx)] = 64'd0;
        if (shard_fill[s] > 0)
            shard_fill[s]--;
        cur = idx;
        nxt = (cur + 1) % NB;
        for (int n = 0; n < NB; n++)
        begin
            k = key_mem[bucket_at(s, nxt)];
            if (k == 64'd0)
                break;
            ideal = home_bucket(k);
            dn = (nxt - ideal + NB) % NB;
            dc = (cur - ideal + NB) % NB;
            if (dc < dn)
            begin
                key_mem[bucket_at(s, cur)] = k;
                data_mem[bucket_at(s, cur)] = data_mem[bucket_at(s, nxt)];
                key_mem[bucket_at(s, nxt)] = 64'd0;
                data_mem[bucket_at(s, nxt)] = 64'd0;
                cur = nxt;
            end
            nxt = (nxt + 1) % NB;
        end
    endfunction

    function automatic void store_at_free(int s, logic [63:0] k, logic [63:0] d);
        int idx;
        idx = home_bucket(k);
        for (int n = 0; n < NB; n++)
        begin
            if (key_mem[bucket_at(s, idx)] == 64'd0)
            begin
                key_mem[bucket_at(s, idx)] = k;
                data_mem[bucket_at(s, idx)] = d;
                shard_fill[s]++;
                return;
            end
            idx = (idx + 1) % NB;
        end
    endfunction

    function automatic logic [2:0] insert_key(logic [63:0] k, logic [63:0] d);
        int s;
        int pos;
        s = shard_sel(k);
        if (shard_fill[s] >= int'(load_limit) || shard_fill[s] + 1 >= NB)
            return ST_FULL;
        if (find_bucket(s, k, pos))
            return ST_EXISTS;
        store_at_free(s, k, d);
        return ST_OK;
    endfunction

    function automatic map_reply_t map_reply(logic [1:0] op, logic [63:0] k,
                                             logic [63:0] nk, logic [63:0] d);
        map_reply_t r;
        int s;
        int sn;
        int pos;
        r.status = ST_OK;
        r.data = 64'd0;
        s = shard_sel(k);
        sn = shard_sel(nk);
        if (k == 64'd0 || (op == CMD_UPDATE && nk == 64'd0))
            r.status = ST_ZERO_KEY;
        else if (op == CMD_FIND)
        begin
            if (find_bucket(s, k, pos))
                r.data = data_mem[bucket_at(s, pos)];
            else
                r.status = ST_NOT_FOUND;
        end
        else if (op == CMD_INSERT)
            r.status = insert_key(k, d);
        else if (op == CMD_UPDATE)
        begin
            if (!find_bucket(s, k, pos))
                r.status = ST_NOT_FOUND;
            else if (k == nk)
                data_mem[bucket_at(s, pos)] = d;
            else
            begin
                shift_back_from(s, pos);
                if (s != sn)
                    r.status = insert_key(nk, d);
                else
                    store_at_free(s, nk, d);
            end
        end
        else
        begin
            if (find_bucket(s, k, pos))
            begin
                r.data = data_mem[bucket_at(s, pos)];
                shift_back_from(s, pos);
            end
            else
                r.status = ST_NOT_FOUND;
        end
        return r;
    endfunction

    assign pending = replies_due.size();

    initial
    begin
        for (int i = 0; i < NS*NB; i++)
        begin
            key_mem[i] = 64'd0;
            data_mem[i] = 64'd0;
        end
        for (int i = 0; i < NS; i++)
            shard_fill[i] = 0;
        load_limit = LOAD_LIMIT_RST;
        errors = 0;
        words_done = 0;
    end

    always @(posedge clk)
    begin
        map_reply_t got;
        map_reply_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready
                && paddr == PADDR_W'(4 * REG_LOAD_LIMIT))
                load_limit = pwdata[7:0];
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = out_ch.status;
                got.data = out_ch.data_out;
                words_done++;
                if (replies_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word status %0d data %h",
                             $time, got.status, got.data);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.data !== want.data)
                    begin
                        errors++;
                        $display("%0t: data_out expected %h actual %h",
                                 $time, want.data, got.data);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                replies_due.push_back(map_reply(in_ch.cmd, in_ch.key,
                                                in_ch.new_key, in_ch.data_in));
        end
    end

endmodule

// ----- bench/sharded_linear_probe_hash_map_tb.sv -----
`timescale 1ns / 100ps

module sharded_linear_probe_hash_map_tb;
    import slph_pkg::*;

    localparam logic [63:0] FIB_MUL = {FIB_HI, FIB_LO};

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int errors;
    int pending;
    int words_done;
    int send_gap_pct;
    int recv_stall_pct;
    logic [63:0] key_pool [48];

    slph_in_if  in_ch ();
    slph_out_if out_ch ();

    sharded_linear_probe_hash_map DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    slph_map_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch),
        .errors(errors), .pending(pending), .words_done(words_done)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        out_ch.ready = (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] clustered_key(int shard, int home_top);
        logic [63:0] k;
        logic [63:0] h;
        do
        begin
            k = rand64();
            h = k * FIB_MUL;
        end while (k == 64'd0 || int'(h[63:60]) != shard
                   || (home_top >= 0 && int'(h[39:35]) != home_top));
        return k;
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 64'd0;
        if (r < 12)
            return rand64();
        return key_pool[$urandom_range(0, 47)];
    endfunction

    task automatic send_word(logic [1:0] op, logic [63:0] k, logic [63:0] nk,
                             logic [63:0] d);
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.cmd = op;
        in_ch.key = k;
        in_ch.new_key = nk;
        in_ch.data_in = d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_limit(logic [7:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_W'(4 * REG_LOAD_LIMIT);
        pwdata = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        wait (pending == 0);
        @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    task automatic random_word();
        logic [1:0] op;
        logic [63:0] k;
        logic [63:0] nk;
        logic [63:0] d;
        op = 2'($urandom_range(0, 3));
        k = pick_key();
        nk = ($urandom_range(0, 3) == 0) ? k : pick_key();
        d = ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
        send_word(op, k, nk, d);
    endtask

    initial
    begin
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [7:0] limits [8] = '{8'd3, 8'd255, 8'd1, 8'd40, 8'd192, 8'd2, 8'd255, 8'd1};
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_FIND;
        in_ch.key = '0;
        in_ch.new_key = '0;
        in_ch.data_in = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        out_ch.ready = 1'b1;
        for (int i = 0; i < 48; i++)
            key_pool[i] = (i < 16) ? clustered_key(2, 0)
                        : (i < 32) ? clustered_key(2, 31) : clustered_key(9, -1);
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        a = key_pool[0];
        b = key_pool[1];
        c = key_pool[40];
        send_word(CMD_FIND, 64'd0, 64'd0, 64'd0);
        send_word(CMD_INSERT, 64'd0, 64'd0, 64'd5);
        send_word(CMD_UPDATE, a, 64'd0, 64'd5);
        send_word(CMD_UPDATE, 64'd0, a, 64'd5);
        send_word(CMD_DELETE, 64'd0, 64'd0, 64'd0);
        send_word(CMD_INSERT, '1, '1, '1);
        send_word(CMD_FIND, '1, 64'd0, 64'd0);
        send_word(CMD_INSERT, '1, 64'd0, 64'd7);
        send_word(CMD_INSERT, a, 64'd0, 64'd0);
        send_word(CMD_INSERT, b, 64'd0, 64'h8000_0000_0000_0001);
        send_word(CMD_FIND, a, 64'd0, 64'd0);
        send_word(CMD_UPDATE, a, a, 64'h1234);
        send_word(CMD_UPDATE, b, b, 64'd0);
        send_word(CMD_FIND, b, 64'd0, 64'd0);
        send_word(CMD_DELETE, b, 64'd0, 64'd0);
        send_word(CMD_UPDATE, a, c, 64'hABCD);
        send_word(CMD_UPDATE, c, key_pool[41], 64'h55);
        send_word(CMD_UPDATE, key_pool[41], key_pool[2], 64'h66);
        send_word(CMD_FIND, key_pool[2], 64'd0, 64'd0);
        send_word(CMD_UPDATE, b, a, 64'd1);
        send_word(CMD_DELETE, b, 64'd0, 64'd0);
        send_word(CMD_FIND, c, 64'd0, 64'd0);
        send_word(CMD_DELETE, '1, 64'd0, 64'd0);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_limit(limits[p]);
            send_gap_pct = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 25 : 0;
            recv_stall_pct = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 25 : 0;
            for (int i = 0; i < 75; i++)
                random_word();
        end

        drain();
        repeat (200)
            @(negedge clk);
        $display("Covered %0d result words over 8 load limits from 1 to 255,",
                 words_done);
        $display("with clustered and wrapping probes, shifts and full shards.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/slph_pkg.sv
rtl/core/slph_if.sv
rtl/core/slph_hash.sv
rtl/core/slph_store.sv
rtl/core/slph_ctrl.sv
rtl/core/sharded_linear_probe_hash_map.sv
rtl/core/slph_checker.sv
bench/slph_map_checker.sv
bench/sharded_linear_probe_hash_map_tb.sv
